// ----- rtl/core/mvgs_pkg.sv -----
// Shared types and constants for the masked volume gradient statistics block.
// No dependencies; imported by every module under rtl/core.
package mvgs_pkg;

    localparam int MAX_X_DEF = 64;
    localparam int MAX_Y_DEF = 64;
    localparam int MAX_Z_DEF = 64;

    localparam int CFG_W   = 7;
    localparam int CNT_W   = 19;
    localparam int SUM_W   = 36;
    localparam int SQ_W    = 51;
    localparam int VAL_W   = 16;
    localparam int DIFF_W  = VAL_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQR_W   = PROD_W - 1;
    localparam int NGROUPS = 4;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    // configuration register indexes
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // statistic groups
    localparam logic [1:0] GRP_IMG = 2'd0;
    localparam logic [1:0] GRP_X   = 2'd1;
    localparam logic [1:0] GRP_Y   = 2'd2;
    localparam logic [1:0] GRP_Z   = 2'd3;

    localparam logic [7:0] MASK_INSIDE = 8'd1;

    typedef struct packed {
        logic                    is_inside;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    // one voxel's contributions, one lane per group
    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic [NGROUPS-1:0]             en;
        logic [NGROUPS-1:0][DIFF_W-1:0] val;
    } term_t;

    // run totals handed to the result bank
    typedef struct packed {
        logic                          load;
        logic [NGROUPS-1:0][CNT_W-1:0] cnt;
        logic [NGROUPS-1:0][SUM_W-1:0] sum;
        logic [NGROUPS-1:0][SQ_W-1:0]  sq;
    } totals_t;

endpackage

// ----- rtl/core/mvgs_store.sv -----
// Row and slice neighbor memories with a registered read.
// Depends on mvgs_pkg (entry_t).
module mvgs_store import mvgs_pkg::*; #(
    parameter  int MAX_X = MAX_X_DEF,
    parameter  int MAX_Y = MAX_Y_DEF,
    localparam int XW    = $clog2(MAX_X),
    localparam int YW    = $clog2(MAX_Y)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [XW-1:0] rd_x,
    input  logic [YW-1:0] rd_y,
    input  logic          wr_en,
    input  logic [XW-1:0] wr_x,
    input  logic [YW-1:0] wr_y,
    input  entry_t        wr_data,
    output entry_t        row_q,
    output entry_t        slice_q
);

    localparam int SLICE_DEPTH = 1 << (XW + YW);

    entry_t row_mem   [MAX_X];
    entry_t slice_mem [SLICE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_x]         <= wr_data;
            slice_mem[{wr_y, wr_x}] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            row_q   <= row_mem[rd_x];
            slice_q <= slice_mem[{rd_y, rd_x}];
        end
    end

endmodule

// ----- rtl/core/mvgs_accum.sv -----
// Square and accumulate pipeline for the four statistic groups.
// Depends on mvgs_pkg (term_t, totals_t, widths).
module mvgs_accum import mvgs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    clear,
    input  term_t   term_in,
    output logic    last_pending,
    output totals_t totals
);

    term_t                           a_reg;
    logic                            b_valid_reg;
    logic                            b_last_reg;
    logic [NGROUPS-1:0]              b_en_reg;
    logic [NGROUPS-1:0][DIFF_W-1:0]  b_val_reg;
    logic [NGROUPS-1:0][SQR_W-1:0]   b_sq_reg;
    logic [NGROUPS-1:0][SQR_W-1:0]   sq_next;

    logic [NGROUPS-1:0][CNT_W-1:0]   cnt_reg;
    logic [NGROUPS-1:0][SUM_W-1:0]   sum_reg;
    logic [NGROUPS-1:0][SQ_W-1:0]    sq_reg;
    logic [NGROUPS-1:0][CNT_W-1:0]   cnt_next;
    logic [NGROUPS-1:0][SUM_W-1:0]   sum_next;
    logic [NGROUPS-1:0][SQ_W-1:0]    sqs_next;

    always_comb begin
        logic signed [PROD_W-1:0] prod;
        for (int g = 0; g < NGROUPS; g++) begin
            prod       = $signed(a_reg.val[g]) * $signed(a_reg.val[g]);
            sq_next[g] = prod[SQR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.valid <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_reg.valid <= term_in.valid;
            b_valid_reg <= a_reg.valid;
        end
        a_reg.last <= term_in.last;
        a_reg.en   <= term_in.en;
        a_reg.val  <= term_in.val;
        b_last_reg <= a_reg.last;
        b_en_reg   <= a_reg.en;
        b_val_reg  <= a_reg.val;
        b_sq_reg   <= sq_next;
    end

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            cnt_next[g] = cnt_reg[g] + CNT_W'(b_en_reg[g]);
            sum_next[g] = b_en_reg[g] ? sum_reg[g] + SUM_W'($signed(b_val_reg[g]))
                                      : sum_reg[g];
            sqs_next[g] = b_en_reg[g] ? sq_reg[g] + SQ_W'(b_sq_reg[g]) : sq_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (b_valid_reg) begin
            if (b_last_reg) begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end else begin
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
                sq_reg  <= sqs_next;
            end
        end
    end

    assign totals.load = b_valid_reg & b_last_reg;
    assign totals.cnt  = cnt_next;
    assign totals.sum  = sum_next;
    assign totals.sq   = sqs_next;

    assign last_pending = (a_reg.valid & a_reg.last) | (b_valid_reg & b_last_reg);

endmodule

// ----- rtl/core/mvgs_result.sv -----
// Result bank: holds one run's totals and sends them as four words.
// Depends on mvgs_pkg (totals_t, group codes).
module mvgs_result import mvgs_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  totals_t                 totals,
    output logic                    busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_stat_group,
    output logic [CNT_W-1:0]        m_term_count,
    output logic signed [SUM_W-1:0] m_term_sum,
    output logic [SQ_W-1:0]         m_term_square_sum,
    output logic                    m_last_of_run
);

    logic [NGROUPS-1:0][CNT_W-1:0] cnt_reg;
    logic [NGROUPS-1:0][SUM_W-1:0] sum_reg;
    logic [NGROUPS-1:0][SQ_W-1:0]  sq_reg;
    logic                          valid_reg;
    logic [1:0]                    idx_reg;

    always_ff @(posedge aclk) begin
        if (totals.load) begin
            cnt_reg <= totals.cnt;
            sum_reg <= totals.sum;
            sq_reg  <= totals.sq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= GRP_IMG;
        end else if (totals.load) begin
            valid_reg <= 1'b1;
            idx_reg   <= GRP_IMG;
        end else if (valid_reg && m_ready) begin
            if (idx_reg == GRP_Z) begin
                valid_reg <= 1'b0;
                idx_reg   <= GRP_IMG;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    assign busy              = valid_reg;
    assign m_valid           = valid_reg;
    assign m_stat_group      = idx_reg;
    assign m_term_count      = cnt_reg[idx_reg];
    assign m_term_sum        = $signed(sum_reg[idx_reg]);
    assign m_term_square_sum = sq_reg[idx_reg];
    assign m_last_of_run     = (idx_reg == GRP_Z);

endmodule

// ----- rtl/core/masked_volume_gradient_statistics_top.sv -----
// Top level: raster position tracking, neighbor differences, glue to the
// store, accumulator and result modules. Depends on mvgs_pkg.
//
// Usage: voxels arrive on the s_ channel in raster order (x fastest, then
// y, then z), one word per voxel: a signed 16-bit sample and a mask byte,
// where only a mask of exactly 1 counts as inside. The volume size comes
// from size_x/y/z (indexes 0..2 on the cfg_ write port, clamped to 2..MAX);
// any write to one of them restarts the run. After the last voxel of a
// volume the m_ channel carries four words: image, x, y and z statistics
// (count, sum, sum of squares), the z word flagged by m_last_of_run.
// Throughput is one voxel per cycle but for the last-voxel wait below; the
// row/slice neighbor lookup reads each memory once per voxel, writing back
// in the following cycle. The last voxel passes the s1, a and b registers to
// the result bank; its four words go one per cycle while m_ready is high.
// A stalled receiver holds the result bank; voxels of the next run keep
// flowing until that run's last voxel, which waits for the bank to drain.
// Reset clears positions and accumulators and sets all sizes to 64; the
// neighbor memories need no clearing since each entry is written in a run
// before it is read.
module masked_volume_gradient_statistics_top import mvgs_pkg::*; #(
    parameter int MAX_X = MAX_X_DEF,
    parameter int MAX_Y = MAX_Y_DEF,
    parameter int MAX_Z = MAX_Z_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_voxel_value,
    input  logic [7:0]              s_mask_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_stat_group,
    output logic [CNT_W-1:0]        m_term_count,
    output logic signed [SUM_W-1:0] m_term_sum,
    output logic [SQ_W-1:0]         m_term_square_sum,
    output logic                    m_last_of_run
);

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);

    logic [CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [XW-1:0]    pos_x_reg;
    logic [YW-1:0]    pos_y_reg;
    logic [ZW-1:0]    pos_z_reg;
    logic             cfg_clear;
    logic             end_x, end_y, end_z, at_last;
    logic             accept;

    logic             s1_valid_reg, s1_last_reg;
    logic             s1_gx_reg, s1_gy_reg, s1_gz_reg;
    entry_t           s1_cur_reg;
    logic [XW-1:0]    s1_x_reg;
    logic [YW-1:0]    s1_y_reg;
    entry_t           prev_reg;
    entry_t           row_q, slice_q;

    term_t            term;
    totals_t          totals;
    logic             last_pending, res_busy;

    function automatic logic is_end(input int pos, input int cfg, input int maxv);
        int eff;
        eff = (cfg < 2) ? 2 : ((cfg > maxv) ? maxv : cfg);
        return (pos + 1) == eff;
    endfunction

    assign cfg_clear = cfg_wr_en && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                                     cfg_index == REG_SIZE_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign end_x   = is_end(int'(pos_x_reg), int'(size_x_reg), MAX_X);
    assign end_y   = is_end(int'(pos_y_reg), int'(size_y_reg), MAX_Y);
    assign end_z   = is_end(int'(pos_z_reg), int'(size_z_reg), MAX_Z);
    assign at_last = end_x && end_y && end_z;

    // the last voxel of a run needs a free result bank when it lands
    assign s_ready = !(at_last && (s1_last_reg || last_pending || res_busy));
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end else if (accept) begin
            if (end_x) begin
                pos_x_reg <= '0;
                if (end_y) begin
                    pos_y_reg <= '0;
                    pos_z_reg <= end_z ? '0 : pos_z_reg + ZW'(1);
                end else begin
                    pos_y_reg <= pos_y_reg + YW'(1);
                end
            end else begin
                pos_x_reg <= pos_x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && at_last;
        end
        if (accept) begin
            s1_gx_reg            <= (pos_x_reg != '0);
            s1_gy_reg            <= (pos_y_reg != '0);
            s1_gz_reg            <= (pos_z_reg != '0);
            s1_cur_reg.is_inside <= (s_mask_byte == MASK_INSIDE);
            s1_cur_reg.value     <= s_voxel_value;
            s1_x_reg             <= pos_x_reg;
            s1_y_reg             <= pos_y_reg;
        end
        if (s1_valid_reg) begin
            prev_reg <= s1_cur_reg;
        end
    end

    mvgs_store #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_x    (pos_x_reg),
        .rd_y    (pos_y_reg),
        .wr_en   (s1_valid_reg),
        .wr_x    (s1_x_reg),
        .wr_y    (s1_y_reg),
        .wr_data (s1_cur_reg),
        .row_q   (row_q),
        .slice_q (slice_q)
    );

    always_comb begin
        term.valid        = s1_valid_reg;
        term.last         = s1_last_reg;
        term.en[GRP_IMG]  = s1_cur_reg.is_inside;
        term.en[GRP_X]    = s1_gx_reg && s1_cur_reg.is_inside && prev_reg.is_inside;
        term.en[GRP_Y]    = s1_gy_reg && s1_cur_reg.is_inside && row_q.is_inside;
        term.en[GRP_Z]    = s1_gz_reg && s1_cur_reg.is_inside && slice_q.is_inside;
        term.val[GRP_IMG] = DIFF_W'(s1_cur_reg.value);
        term.val[GRP_X]   = DIFF_W'(s1_cur_reg.value) - DIFF_W'(prev_reg.value);
        term.val[GRP_Y]   = DIFF_W'(s1_cur_reg.value) - DIFF_W'(row_q.value);
        term.val[GRP_Z]   = DIFF_W'(s1_cur_reg.value) - DIFF_W'(slice_q.value);
    end

    mvgs_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (cfg_clear),
        .term_in      (term),
        .last_pending (last_pending),
        .totals       (totals)
    );

    mvgs_result u_result (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .totals            (totals),
        .busy              (res_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_stat_group      (m_stat_group),
        .m_term_count      (m_term_count),
        .m_term_sum        (m_term_sum),
        .m_term_square_sum (m_term_square_sum),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

// ----- test/masked_volume_gradient_statistics_top_tb.sv -----
// Testbench for masked_volume_gradient_statistics_top: streams small volumes,
// predicts the four statistic words per volume and checks them word by word.
// Depends on mvgs_pkg and the top-level RTL only.
module masked_volume_gradient_statistics_top_tb;
    import mvgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index past the register list: accepted by the port, changes nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int SLICE_DEPTH = MAX_X_DEF * MAX_Y_DEF;

    typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_e;

    typedef struct {
        logic [1:0]       grp;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic             last;
    } stat_word_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [1:0]              cfg_index = REG_SIZE_X;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_voxel_value = '0;
    logic [7:0]              s_mask_byte = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_stat_group;
    logic [CNT_W-1:0]        m_term_count;
    logic signed [SUM_W-1:0] m_term_sum;
    logic [SQ_W-1:0]         m_term_square_sum;
    logic                    m_last_of_run;

    masked_volume_gradient_statistics_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_voxel_value     (s_voxel_value),
        .s_mask_byte       (s_mask_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_stat_group      (m_stat_group),
        .m_term_count      (m_term_count),
        .m_term_sum        (m_term_sum),
        .m_term_square_sum (m_term_square_sum),
        .m_last_of_run     (m_last_of_run)
    );

    // shadow of the block's volume state
    logic [CFG_W-1:0] vol_size [3] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    int               scan_x = 0;
    int               scan_y = 0;
    int               scan_z = 0;
    entry_t           prev_entry = '0;
    entry_t           row_mem [MAX_X_DEF];
    entry_t           slice_mem [SLICE_DEPTH];
    logic [CNT_W-1:0] grp_count [NGROUPS] = '{default: '0};
    logic [SUM_W-1:0] grp_sum [NGROUPS] = '{default: '0};
    logic [SQ_W-1:0]  grp_sq [NGROUPS] = '{default: '0};

    stat_word_t expected_stats[$];
    int         mismatch_count = 0;
    int         tx_burst_left = 0;

    rx_mode_e    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_hold = 0;
    logic        rx_level = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_size(input logic [CFG_W-1:0] raw, input int maxv);
        if (raw < 2) return 2;
        if (raw > maxv) return maxv;
        return int'(raw);
    endfunction

    function automatic int volume_len();
        return eff_size(vol_size[0], MAX_X_DEF) * eff_size(vol_size[1], MAX_Y_DEF)
             * eff_size(vol_size[2], MAX_Z_DEF);
    endfunction

    function automatic void clear_totals();
        scan_x = 0;
        scan_y = 0;
        scan_z = 0;
        prev_entry = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            grp_count[g] = '0;
            grp_sum[g] = '0;
            grp_sq[g] = '0;
        end
    endfunction

    function automatic void add_term(input int g, input longint v);
        grp_count[g] = grp_count[g] + 1'b1;
        grp_sum[g] = grp_sum[g] + SUM_W'(v);
        grp_sq[g] = grp_sq[g] + SQ_W'(v * v);
    endfunction

    function automatic void add_pair(input int g, input entry_t cur, input entry_t nb);
        if (cur.is_inside && nb.is_inside)
            add_term(g, longint'($signed(cur.value)) - longint'($signed(nb.value)));
    endfunction

    // one accepted voxel; pushes the four words when it closes the volume
    function automatic void predict_voxel(input logic signed [VAL_W-1:0] value,
                                          input logic [7:0] mask);
        int         sx;
        int         sy;
        int         sz;
        int         sidx;
        entry_t     cur;
        stat_word_t word;
        sx = eff_size(vol_size[0], MAX_X_DEF);
        sy = eff_size(vol_size[1], MAX_Y_DEF);
        sz = eff_size(vol_size[2], MAX_Z_DEF);
        if (scan_x >= sx || scan_y >= sy || scan_z >= sz) clear_totals();
        sidx = scan_y * MAX_X_DEF + scan_x;
        cur.value = value;
        cur.is_inside = (mask == MASK_INSIDE);
        if (cur.is_inside) add_term(GRP_IMG, longint'(value));
        if (scan_x > 0) add_pair(GRP_X, cur, prev_entry);
        if (scan_y > 0) add_pair(GRP_Y, cur, row_mem[scan_x]);
        if (scan_z > 0) add_pair(GRP_Z, cur, slice_mem[sidx]);
        prev_entry = cur;
        row_mem[scan_x] = cur;
        slice_mem[sidx] = cur;
        scan_x++;
        if (scan_x < sx) return;
        scan_x = 0;
        scan_y++;
        if (scan_y < sy) return;
        scan_y = 0;
        scan_z++;
        if (scan_z < sz) return;
        for (int g = 0; g < NGROUPS; g++) begin
            word.grp = 2'(g);
            word.count = grp_count[g];
            word.sum = grp_sum[g];
            word.sq = grp_sq[g];
            word.last = (2'(g) == GRP_Z);
            expected_stats.push_back(word);
        end
        clear_totals();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // all tasks below are entered and left right after a rising edge
    task automatic send_voxel(input logic signed [VAL_W-1:0] value, input logic [7:0] mask);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        tx_burst_left--;
        s_valid <= 1'b1;
        s_voxel_value <= value;
        s_mask_byte <= mask;
        do @(posedge aclk); while (!s_ready);
        predict_voxel(value, mask);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    default: return -16'sd1;
                endcase
            end
            1, 2: return VAL_W'(int'($urandom_range(0, 32)) - 16);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_mask();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return MASK_INSIDE;
        if (r < 8) return 8'd0;
        return 8'($urandom_range(2, 255));
    endfunction

    task automatic send_voxels(input int n);
        repeat (n) send_voxel(pick_value(), pick_mask());
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge aclk);
        if (index != REG_UNUSED) begin
            vol_size[index] = data;
            clear_totals();
        end
    endtask

    task automatic cfg_release();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic cfg_sizes(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                             input logic [CFG_W-1:0] sz);
        cfg_write(REG_SIZE_X, sx);
        cfg_write(REG_SIZE_Y, sy);
        cfg_write(REG_SIZE_Z, sz);
        cfg_release();
    endtask

    // block is idle once every word is back and the pipeline has flushed
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // 2x2x2 checkerboard of full-scale values: every difference is +/-65535
    task automatic test_value_extremes();
        int x;
        int y;
        int z;
        drain_results();
        cfg_sizes(7'd0, 7'd1, 7'd2);
        for (int i = 0; i < 8; i++) begin
            x = i % 2;
            y = (i / 2) % 2;
            z = i / 4;
            send_voxel(((x + y + z) % 2 != 0) ? 16'sh7FFF : 16'sh8000, MASK_INSIDE);
        end
    endtask

    task automatic test_mask_codes_and_unused_index();
        logic [7:0]              masks [8] = '{8'd1, 8'd0, 8'd1, 8'd254, 8'd255, 8'd1,
                                                8'd128, 8'd1};
        logic signed [VAL_W-1:0] vals [8] = '{-16'sd5, 16'sd7, 16'sd300, -16'sd300,
                                               16'sd12, -16'sd32768, 16'sd9, 16'sd32767};
        drain_results();
        cfg_sizes(7'd2, 7'd2, 7'd2);
        for (int i = 0; i < 3; i++) send_voxel(vals[i], masks[i]);
        // a write past the register list must not restart the volume
        drain_results();
        cfg_write(REG_UNUSED, 7'h7F);
        cfg_release();
        for (int i = 3; i < 8; i++) send_voxel(vals[i], masks[i]);
    endtask

    task automatic test_restart_on_write();
        drain_results();
        send_voxels(2);
        drain_results();
        cfg_write(REG_SIZE_X, 7'd2);
        cfg_release();
        send_voxels(8);
    endtask

    // many small volumes under changing sizes, some cut short by a restart
    task automatic test_random_small_volumes();
        int sent;
        int vol;
        int cut;
        int reps;
        sent = 0;
        while (sent < 100) begin
            drain_results();
            cfg_write(REG_SIZE_X, 7'($urandom_range(0, 4)));
            cfg_write(REG_SIZE_Y, 7'($urandom_range(0, 4)));
            cfg_write(REG_SIZE_Z, 7'($urandom_range(0, 4)));
            if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, 7'($urandom));
            cfg_release();
            vol = volume_len();
            if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, vol - 1);
                send_voxels(cut);
                sent += cut;
                drain_results();
                cfg_write(2'($urandom_range(0, 2)), 7'($urandom_range(0, 4)));
                cfg_release();
                vol = volume_len();
            end
            reps = $urandom_range(1, 3);
            send_voxels(reps * vol);
            sent += reps * vol;
        end
    endtask

    // x at its largest size, out-of-range writes clamped from above and below
    task automatic test_axis_extremes();
        drain_results();
        cfg_sizes(7'd127, 7'd0, 7'd1);
        send_voxels(volume_len());
    endtask

    // receiver: modes of random length, from always ready to long stalls
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold == 0) begin
                    rx_level = !rx_level;
                    rx_hold = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 30);
                end
                rx_hold--;
                m_ready <= rx_level;
            end
        endcase
    end

    always @(posedge aclk) begin : check_results
        stat_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch($sformatf("unexpected word, group %0d", m_stat_group));
            end else begin
                want = expected_stats.pop_front();
                if (m_stat_group !== want.grp)
                    report_mismatch($sformatf("group %0d, want %0d", m_stat_group, want.grp));
                if (m_term_count !== want.count)
                    report_mismatch($sformatf("group %0d count %0d, want %0d",
                                              want.grp, m_term_count, want.count));
                if (m_term_sum !== want.sum)
                    report_mismatch($sformatf("group %0d sum %0d, want %0d", want.grp,
                                              m_term_sum, $signed(want.sum)));
                if (m_term_square_sum !== want.sq)
                    report_mismatch($sformatf("group %0d square sum %0d, want %0d",
                                              want.grp, m_term_square_sum, want.sq));
                if (m_last_of_run !== want.last)
                    report_mismatch($sformatf("group %0d last %0b, want %0b",
                                              want.grp, m_last_of_run, want.last));
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_value_extremes();
        test_mask_codes_and_unused_index();
        test_restart_on_write();
        test_random_small_volumes();
        test_axis_extremes();
        drain_results();
        repeat (20) @(posedge aclk);
        if (expected_stats.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_stats.size()));
        if (mismatch_count == 0) begin
            $display("masked_volume_gradient_statistics_top_tb: done, clean");
        end else begin
            $display("masked_volume_gradient_statistics_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[%0t] timeout", $realtime);
        $display("masked_volume_gradient_statistics_top_tb: done, errors");
        $finish;
    end

endmodule
